### rtl/core/utf8_glyph_layout_engine_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the glyph layout engine
// Clocked assertions on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef UTF8_GLYPH_LAYOUT_ENGINE_TOP_MACROS_SVH
`define UTF8_GLYPH_LAYOUT_ENGINE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UGL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UGL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/ugl_pkg.sv
// ---------------------------------------------------------------------------
// ugl_pkg
// Shared types, constants and helper functions of the glyph layout engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ugl_pkg;

  localparam int GLYPH_ENTRIES_DEF   = 128;
  localparam int SCALE_FRAC_BITS_DEF = 8;

  localparam int BYTE_W        = 8;
  localparam int KEY_W         = 32;
  localparam int KEY_LEN_W     = 3;
  localparam int COORD_W       = 12;
  localparam int POS_W         = 16;
  localparam int SIZE_W        = 16;
  localparam int SCALE_W       = 12;
  localparam int MATCH_INDEX_W = 7;
  localparam int PEND_CNT_W    = 3;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 12'd256;
  localparam logic signed [POS_W-1:0] POS_MAX = 16'sh7FFF;

  localparam logic [BYTE_W-1:0] UTF8_MASK_1 = 8'h80;
  localparam logic [BYTE_W-1:0] UTF8_MASK_2 = 8'hE0;
  localparam logic [BYTE_W-1:0] UTF8_LEAD_2 = 8'hC0;
  localparam logic [BYTE_W-1:0] UTF8_MASK_3 = 8'hF0;
  localparam logic [BYTE_W-1:0] UTF8_LEAD_3 = 8'hE0;
  localparam logic [BYTE_W-1:0] UTF8_MASK_4 = 8'hF8;
  localparam logic [BYTE_W-1:0] UTF8_LEAD_4 = 8'hF0;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_START  = 2'd2,
    CMD_TEXT   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [KEY_W-1:0]     key;
    logic [KEY_LEN_W-1:0] key_len;
    logic [COORD_W-1:0]   rect_h;
    logic [COORD_W-1:0]   rect_w;
    logic [COORD_W-1:0]   rect_y;
    logic [COORD_W-1:0]   rect_x;
    logic [COORD_W-1:0]   advance;
  } glyph_entry_t;

  function automatic logic [KEY_LEN_W-1:0] lead_length(input logic [BYTE_W-1:0] b);
    logic [KEY_LEN_W-1:0] len;
    if ((b & UTF8_MASK_1) == '0) begin
      len = 3'd1;
    end else if ((b & UTF8_MASK_2) == UTF8_LEAD_2) begin
      len = 3'd2;
    end else if ((b & UTF8_MASK_3) == UTF8_LEAD_3) begin
      len = 3'd3;
    end else if ((b & UTF8_MASK_4) == UTF8_LEAD_4) begin
      len = 3'd4;
    end else begin
      len = 3'd1;
    end
    return len;
  endfunction

  function automatic logic [KEY_W-1:0] key_mask(input logic [KEY_LEN_W-1:0] len);
    logic [KEY_W-1:0] mask;
    for (int k = 0; k < KEY_W / BYTE_W; k++) begin
      mask[k*BYTE_W +: BYTE_W] = (32'(len) > k) ? 8'hFF : 8'h00;
    end
    return mask;
  endfunction

endpackage

`default_nettype wire

### rtl/core/ugl_ram.sv
// ---------------------------------------------------------------------------
// ugl_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ugl_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/core/ugl_scaler.sv
// ---------------------------------------------------------------------------
// ugl_scaler
// Shared fixed-point scaling unit: value times scale, truncated, saturated.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ugl_scaler #(
  parameter int SCALE_FRAC_BITS = 8
) (
  input  wire logic                         clk,
  input  wire logic [ugl_pkg::COORD_W-1:0]  value,
  input  wire logic [ugl_pkg::SCALE_W-1:0]  scale,
  output logic      [ugl_pkg::SIZE_W-1:0]   result
);
  import ugl_pkg::*;

  localparam int PROD_W = COORD_W + SCALE_W;

  logic [PROD_W-1:0] product;
  logic [PROD_W-1:0] shifted;
  logic [SIZE_W-1:0] result_nxt;

  assign product = PROD_W'(value) * PROD_W'(scale);
  assign shifted = product >> SCALE_FRAC_BITS;

  always_comb begin
    if (|shifted[PROD_W-1:SIZE_W]) begin
      result_nxt = '1;
    end else begin
      result_nxt = shifted[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    result <= result_nxt;
  end

endmodule

`default_nettype wire

### rtl/core/utf8_glyph_layout_engine_top.sv
// ---------------------------------------------------------------------------
// utf8_glyph_layout_engine_top
// Gathers UTF-8 text into characters, looks them up in the glyph table and
// emits one blit word per character.
// ---------------------------------------------------------------------------
// Clear, append, start and incomplete text bytes finish without leaving idle; busy stays low.
// A completed character searches the table one entry per cycle: a hit passes through
// MUL_W, MUL_H, MUL_A and EMIT before its word is strobed, a miss strobes once every
// entry has been checked, and busy drops with the strobe.
// Results cannot be stalled; each word is valid for exactly one cycle.
// Reset clears the control state, the entry count, the pen and sets scale one.
`timescale 1ns / 1ps
`default_nettype none

module utf8_glyph_layout_engine_top #(
  parameter int GLYPH_ENTRIES   = ugl_pkg::GLYPH_ENTRIES_DEF,
  parameter int SCALE_FRAC_BITS = ugl_pkg::SCALE_FRAC_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic [1:0]                            in_command,
  input  wire logic [ugl_pkg::BYTE_W-1:0]            in_text_byte,
  input  wire logic signed [ugl_pkg::POS_W-1:0]      in_origin_x,
  input  wire logic signed [ugl_pkg::POS_W-1:0]      in_origin_y,
  input  wire logic [ugl_pkg::SCALE_W-1:0]           in_scale_q4_8,
  input  wire logic [ugl_pkg::KEY_W-1:0]             in_key_bytes,
  input  wire logic [ugl_pkg::KEY_LEN_W-1:0]         in_key_length,
  input  wire logic [ugl_pkg::COORD_W-1:0]           in_rect_x,
  input  wire logic [ugl_pkg::COORD_W-1:0]           in_rect_y,
  input  wire logic [ugl_pkg::COORD_W-1:0]           in_rect_w,
  input  wire logic [ugl_pkg::COORD_W-1:0]           in_rect_h,
  input  wire logic [ugl_pkg::COORD_W-1:0]           in_advance,
  output logic                                       out_strobe,
  output logic                                       out_found,
  output logic [ugl_pkg::MATCH_INDEX_W-1:0]          out_match_index,
  output logic [ugl_pkg::COORD_W-1:0]                out_src_x,
  output logic [ugl_pkg::COORD_W-1:0]                out_src_y,
  output logic [ugl_pkg::COORD_W-1:0]                out_src_w,
  output logic [ugl_pkg::COORD_W-1:0]                out_src_h,
  output logic signed [ugl_pkg::POS_W-1:0]           out_dst_x,
  output logic signed [ugl_pkg::POS_W-1:0]           out_dst_y,
  output logic [ugl_pkg::SIZE_W-1:0]                 out_dst_w,
  output logic [ugl_pkg::SIZE_W-1:0]                 out_dst_h
);
  import ugl_pkg::*;

  `include "utf8_glyph_layout_engine_top_macros.svh"

  localparam int ADDR_W  = (GLYPH_ENTRIES > 1) ? $clog2(GLYPH_ENTRIES) : 1;
  localparam int CNT_W   = $clog2(GLYPH_ENTRIES + 1);
  localparam int ENTRY_W = $bits(glyph_entry_t);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(GLYPH_ENTRIES);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SEARCH = 6'b000010,
    ST_MUL_W  = 6'b000100,
    ST_MUL_H  = 6'b001000,
    ST_MUL_A  = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]      count_r, count_nxt;
  logic signed [POS_W-1:0] pen_x_r, pen_x_nxt;
  logic signed [POS_W-1:0] pen_y_r, pen_y_nxt;
  logic [SCALE_W-1:0]    scale_r, scale_nxt;
  logic [KEY_W-1:0]      pend_bytes_r, pend_bytes_nxt;
  logic [PEND_CNT_W-1:0] pend_cnt_r, pend_cnt_nxt;
  logic [KEY_LEN_W-1:0]  exp_len_r, exp_len_nxt;
  logic [KEY_W-1:0]      key_r, key_nxt;
  logic [KEY_LEN_W-1:0]  klen_r, klen_nxt;
  logic [CNT_W-1:0]      issue_idx_r, issue_idx_nxt;
  logic                  chk_vld_r, chk_vld_nxt;
  logic [ADDR_W-1:0]     chk_idx_r, chk_idx_nxt;
  glyph_entry_t          hit_r, hit_nxt;
  logic [SIZE_W-1:0]     dst_w_r, dst_w_nxt;
  logic [SIZE_W-1:0]     dst_h_r, dst_h_nxt;

  logic                    strobe_r, strobe_nxt;
  logic                    found_r, found_nxt;
  logic [MATCH_INDEX_W-1:0] idx_out_r, idx_out_nxt;
  logic [COORD_W-1:0]      src_x_r, src_x_nxt;
  logic [COORD_W-1:0]      src_y_r, src_y_nxt;
  logic [COORD_W-1:0]      src_w_r, src_w_nxt;
  logic [COORD_W-1:0]      src_h_r, src_h_nxt;
  logic signed [POS_W-1:0] dx_r, dx_nxt;
  logic signed [POS_W-1:0] dy_r, dy_nxt;
  logic [SIZE_W-1:0]       dw_r, dw_nxt;
  logic [SIZE_W-1:0]       dh_r, dh_nxt;

  logic                  accept;
  logic                  ram_we;
  glyph_entry_t          ram_wdata;
  glyph_entry_t          ram_rdata;
  logic [ENTRY_W-1:0]    ram_rdata_raw;
  logic [COORD_W-1:0]    mul_value;
  logic [SIZE_W-1:0]     mul_result;
  logic                  entry_match;
  logic [KEY_LEN_W-1:0]  eff_exp;
  logic [KEY_W-1:0]      new_bytes;
  logic [PEND_CNT_W-1:0] new_cnt;
  logic signed [POS_W+1:0] pen_sum;
  logic [ADDR_W+MATCH_INDEX_W-1:0] idx_ext;
  logic                  miss_word_clear;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  assign ram_we = accept && (cmd_t'(in_command) == CMD_APPEND) && (count_r < FULL_COUNT);

  always_comb begin
    ram_wdata.key     = in_key_bytes & key_mask(in_key_length);
    ram_wdata.key_len = in_key_length;
    ram_wdata.rect_x  = in_rect_x;
    ram_wdata.rect_y  = in_rect_y;
    ram_wdata.rect_w  = in_rect_w;
    ram_wdata.rect_h  = in_rect_h;
    ram_wdata.advance = in_advance;
  end

  ugl_ram #(
    .DATA_W (ENTRY_W),
    .DEPTH  (GLYPH_ENTRIES),
    .ADDR_W (ADDR_W)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (ram_wdata),
    .raddr (issue_idx_r[ADDR_W-1:0]),
    .rdata (ram_rdata_raw)
  );

  assign ram_rdata = glyph_entry_t'(ram_rdata_raw);

  always_comb begin
    case (state_r)
      ST_MUL_H: mul_value = hit_r.rect_h;
      ST_MUL_A: mul_value = hit_r.advance;
      default:  mul_value = hit_r.rect_w;
    endcase
  end

  ugl_scaler #(
    .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
  ) u_scaler (
    .clk    (clk),
    .value  (mul_value),
    .scale  (scale_r),
    .result (mul_result)
  );

  assign entry_match = chk_vld_r && (ram_rdata.key_len == klen_r) && (ram_rdata.key == key_r);
  assign idx_ext     = {{MATCH_INDEX_W{1'b0}}, chk_idx_r};

  assign eff_exp   = (pend_cnt_r == '0) ? lead_length(in_text_byte) : exp_len_r;
  assign new_bytes = ((pend_cnt_r == '0) ? '0 : pend_bytes_r)
                   | (KEY_W'(in_text_byte) << {pend_cnt_r[1:0], 3'b000});
  assign new_cnt   = pend_cnt_r + 1'b1;
  assign pen_sum   = {{2{pen_x_r[POS_W-1]}}, pen_x_r} + $signed({2'b00, mul_result});

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    pen_x_nxt      = pen_x_r;
    pen_y_nxt      = pen_y_r;
    scale_nxt      = scale_r;
    pend_bytes_nxt = pend_bytes_r;
    pend_cnt_nxt   = pend_cnt_r;
    exp_len_nxt    = exp_len_r;
    key_nxt        = key_r;
    klen_nxt       = klen_r;
    issue_idx_nxt  = issue_idx_r;
    chk_vld_nxt    = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    hit_nxt        = hit_r;
    dst_w_nxt      = dst_w_r;
    dst_h_nxt      = dst_h_r;
    strobe_nxt     = 1'b0;
    found_nxt      = found_r;
    idx_out_nxt    = idx_out_r;
    src_x_nxt      = src_x_r;
    src_y_nxt      = src_y_r;
    src_w_nxt      = src_w_r;
    src_h_nxt      = src_h_r;
    dx_nxt         = dx_r;
    dy_nxt         = dy_r;
    dw_nxt         = dw_r;
    dh_nxt         = dh_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_t'(in_command))
            CMD_CLEAR: begin
              count_nxt = '0;
            end
            CMD_APPEND: begin
              if (count_r < FULL_COUNT) begin
                count_nxt = count_r + 1'b1;
              end
            end
            CMD_START: begin
              pen_x_nxt    = in_origin_x;
              pen_y_nxt    = in_origin_y;
              scale_nxt    = in_scale_q4_8;
              pend_bytes_nxt = '0;
              pend_cnt_nxt = '0;
              exp_len_nxt  = '0;
            end
            CMD_TEXT: begin
              if (new_cnt < eff_exp) begin
                pend_bytes_nxt = new_bytes;
                pend_cnt_nxt   = new_cnt;
                exp_len_nxt    = eff_exp;
              end else begin
                key_nxt        = new_bytes;
                klen_nxt       = eff_exp;
                pend_bytes_nxt = '0;
                pend_cnt_nxt   = '0;
                exp_len_nxt    = '0;
                issue_idx_nxt  = '0;
                state_nxt      = ST_SEARCH;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_SEARCH: begin
        if (issue_idx_r < count_r) begin
          issue_idx_nxt = issue_idx_r + 1'b1;
          chk_vld_nxt   = 1'b1;
          chk_idx_nxt   = issue_idx_r[ADDR_W-1:0];
        end
        if (entry_match) begin
          hit_nxt     = ram_rdata;
          chk_vld_nxt = 1'b0;
          chk_idx_nxt = chk_idx_r;
          state_nxt   = ST_MUL_W;
        end else if (!chk_vld_r && (issue_idx_r >= count_r)) begin
          strobe_nxt  = 1'b1;
          found_nxt   = 1'b0;
          idx_out_nxt = '0;
          src_x_nxt   = '0;
          src_y_nxt   = '0;
          src_w_nxt   = '0;
          src_h_nxt   = '0;
          dx_nxt      = pen_x_r;
          dy_nxt      = pen_y_r;
          dw_nxt      = '0;
          dh_nxt      = '0;
          chk_vld_nxt = 1'b0;
          state_nxt   = ST_IDLE;
        end
      end
      ST_MUL_W: begin
        state_nxt = ST_MUL_H;
      end
      ST_MUL_H: begin
        dst_w_nxt = mul_result;
        state_nxt = ST_MUL_A;
      end
      ST_MUL_A: begin
        dst_h_nxt = mul_result;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        strobe_nxt  = 1'b1;
        found_nxt   = 1'b1;
        idx_out_nxt = idx_ext[MATCH_INDEX_W-1:0];
        src_x_nxt   = hit_r.rect_x;
        src_y_nxt   = hit_r.rect_y;
        src_w_nxt   = hit_r.rect_w;
        src_h_nxt   = hit_r.rect_h;
        dx_nxt      = pen_x_r;
        dy_nxt      = pen_y_r;
        dw_nxt      = dst_w_r;
        dh_nxt      = dst_h_r;
        if (pen_sum > 18'(POS_MAX)) begin
          pen_x_nxt = POS_MAX;
        end else begin
          pen_x_nxt = pen_sum[POS_W-1:0];
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      pen_x_r      <= '0;
      pen_y_r      <= '0;
      scale_r      <= SCALE_RESET;
      pend_bytes_r <= '0;
      pend_cnt_r   <= '0;
      exp_len_r    <= '0;
      issue_idx_r  <= '0;
      chk_vld_r    <= 1'b0;
      strobe_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      pen_x_r      <= pen_x_nxt;
      pen_y_r      <= pen_y_nxt;
      scale_r      <= scale_nxt;
      pend_bytes_r <= pend_bytes_nxt;
      pend_cnt_r   <= pend_cnt_nxt;
      exp_len_r    <= exp_len_nxt;
      issue_idx_r  <= issue_idx_nxt;
      chk_vld_r    <= chk_vld_nxt;
      strobe_r     <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    klen_r    <= klen_nxt;
    chk_idx_r <= chk_idx_nxt;
    hit_r     <= hit_nxt;
    dst_w_r   <= dst_w_nxt;
    dst_h_r   <= dst_h_nxt;
    found_r   <= found_nxt;
    idx_out_r <= idx_out_nxt;
    src_x_r   <= src_x_nxt;
    src_y_r   <= src_y_nxt;
    src_w_r   <= src_w_nxt;
    src_h_r   <= src_h_nxt;
    dx_r      <= dx_nxt;
    dy_r      <= dy_nxt;
    dw_r      <= dw_nxt;
    dh_r      <= dh_nxt;
  end

  assign out_strobe      = strobe_r;
  assign out_found       = found_r;
  assign out_match_index = idx_out_r;
  assign out_src_x       = src_x_r;
  assign out_src_y       = src_y_r;
  assign out_src_w       = src_w_r;
  assign out_src_h       = src_h_r;
  assign out_dst_x       = dx_r;
  assign out_dst_y       = dy_r;
  assign out_dst_w       = dw_r;
  assign out_dst_h       = dh_r;

  assign miss_word_clear = (out_dst_w == '0) && (out_dst_h == '0) && (out_match_index == '0);

  `UGL_ASSERT_SAME(a_count_bound, 1'b1, count_r <= FULL_COUNT, "entry count above table depth")
  `UGL_ASSERT_SAME(a_check_in_range, chk_vld_r, 32'(chk_idx_r) < 32'(count_r), "check past count")
  `UGL_ASSERT_NEXT(a_emit_strobes, state_r == ST_EMIT, out_strobe && out_found, "hit did not strobe")
  `UGL_ASSERT_SAME(a_miss_zero, out_strobe && !out_found, miss_word_clear, "miss word not cleared")
  `UGL_ASSERT_NEXT(a_strobe_idle, out_strobe, !out_strobe, "strobe held for two cycles")

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Glyph layout engine regression bench
// Drives clear, append, start and text words into the engine, predicts each
// blit word from a behavioral copy of the glyph table, pen and UTF-8
// gathering, and checks every strobed blit word field by field in order.
// ---------------------------------------------------------------------------
module tb;
  import ugl_pkg::*;

  localparam int GLYPHS     = GLYPH_ENTRIES_DEF;
  localparam int FRAC       = SCALE_FRAC_BITS_DEF;
  localparam int MAX_GAP    = 16;
  localparam int N_WORDS    = 1650;
  localparam int DRAIN      = GLYPHS + 32;
  localparam int IDLE_LIMIT = 4000;

  typedef struct packed {
    cmd_t                 command;
    logic [BYTE_W-1:0]    text_byte;
    logic [POS_W-1:0]     origin_x;
    logic [POS_W-1:0]     origin_y;
    logic [SCALE_W-1:0]   scale_q4_8;
    logic [KEY_W-1:0]     key_bytes;
    logic [KEY_LEN_W-1:0] key_length;
    logic [COORD_W-1:0]   rect_x;
    logic [COORD_W-1:0]   rect_y;
    logic [COORD_W-1:0]   rect_w;
    logic [COORD_W-1:0]   rect_h;
    logic [COORD_W-1:0]   advance;
  } word_t;

  typedef struct packed {
    logic                     found;
    logic [MATCH_INDEX_W-1:0] match_index;
    logic [COORD_W-1:0]       src_x;
    logic [COORD_W-1:0]       src_y;
    logic [COORD_W-1:0]       src_w;
    logic [COORD_W-1:0]       src_h;
    logic [POS_W-1:0]         dst_x;
    logic [POS_W-1:0]         dst_y;
    logic [SIZE_W-1:0]        dst_w;
    logic [SIZE_W-1:0]        dst_h;
  } blit_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  word_t drv = '0;

  logic                       out_strobe;
  logic                       out_found;
  logic [MATCH_INDEX_W-1:0]   out_match_index;
  logic [COORD_W-1:0]         out_src_x;
  logic [COORD_W-1:0]         out_src_y;
  logic [COORD_W-1:0]         out_src_w;
  logic [COORD_W-1:0]         out_src_h;
  logic signed [POS_W-1:0]    out_dst_x;
  logic signed [POS_W-1:0]    out_dst_y;
  logic [SIZE_W-1:0]          out_dst_w;
  logic [SIZE_W-1:0]          out_dst_h;

  word_t pending_words[$];
  blit_t blits_due[$];
  logic [KEY_W-1:0] plan_key[$];
  logic [KEY_LEN_W-1:0] plan_len[$];

  logic [KEY_W-1:0]     atlas_key[GLYPHS];
  logic [KEY_LEN_W-1:0] atlas_len[GLYPHS];
  logic [COORD_W-1:0]   atlas_rx[GLYPHS];
  logic [COORD_W-1:0]   atlas_ry[GLYPHS];
  logic [COORD_W-1:0]   atlas_rw[GLYPHS];
  logic [COORD_W-1:0]   atlas_rh[GLYPHS];
  logic [COORD_W-1:0]   atlas_adv[GLYPHS];
  int                   atlas_used = 0;
  int                   pen_x = 0;
  logic [POS_W-1:0]     pen_y = '0;
  logic [SCALE_W-1:0]   scale = SCALE_RESET;
  logic [KEY_W-1:0]     char_bytes = '0;
  int                   char_have = 0;
  int                   char_need = 0;

  int errors = 0;
  int words_taken = 0;
  int words_total = 0;
  int gap_left = 0;
  int calm_left = 0;
  int quiet_cycles = 0;

  utf8_glyph_layout_engine_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (drv.command),
    .in_text_byte    (drv.text_byte),
    .in_origin_x     (drv.origin_x),
    .in_origin_y     (drv.origin_y),
    .in_scale_q4_8   (drv.scale_q4_8),
    .in_key_bytes    (drv.key_bytes),
    .in_key_length   (drv.key_length),
    .in_rect_x       (drv.rect_x),
    .in_rect_y       (drv.rect_y),
    .in_rect_w       (drv.rect_w),
    .in_rect_h       (drv.rect_h),
    .in_advance      (drv.advance),
    .out_strobe      (out_strobe),
    .out_found       (out_found),
    .out_match_index (out_match_index),
    .out_src_x       (out_src_x),
    .out_src_y       (out_src_y),
    .out_src_w       (out_src_w),
    .out_src_h       (out_src_h),
    .out_dst_x       (out_dst_x),
    .out_dst_y       (out_dst_y),
    .out_dst_w       (out_dst_w),
    .out_dst_h       (out_dst_h)
  );

  always #5 clk = ~clk;

  function automatic int utf8_span(logic [BYTE_W-1:0] b);
    casez (b)
      8'b0???????: return 1;
      8'b110?????: return 2;
      8'b1110????: return 3;
      8'b11110???: return 4;
      default:     return 1;
    endcase
  endfunction

  function automatic int scaled_len(logic [COORD_W-1:0] v);
    int p;
    p = (int'(v) * int'(scale)) >> FRAC;
    return (p > 65535) ? 65535 : p;
  endfunction

  task automatic layout_step(input word_t w);
    blit_t b;
    int hit;
    int k;
    logic [KEY_W-1:0] keep;
    b = '0;
    hit = -1;
    keep = '0;
    case (w.command)
      CMD_CLEAR: begin
        atlas_used = 0;
      end
      CMD_APPEND: begin
        if (atlas_used < GLYPHS) begin
          for (k = 0; k < 4; k++) begin
            if (k < w.key_length) keep[k*8 +: 8] = 8'hFF;
          end
          atlas_key[atlas_used] = w.key_bytes & keep;
          atlas_len[atlas_used] = w.key_length;
          atlas_rx[atlas_used]  = w.rect_x;
          atlas_ry[atlas_used]  = w.rect_y;
          atlas_rw[atlas_used]  = w.rect_w;
          atlas_rh[atlas_used]  = w.rect_h;
          atlas_adv[atlas_used] = w.advance;
          atlas_used++;
        end
      end
      CMD_START: begin
        pen_x = int'($signed(w.origin_x));
        pen_y = w.origin_y;
        scale = w.scale_q4_8;
        char_bytes = '0;
        char_have = 0;
        char_need = 0;
      end
      CMD_TEXT: begin
        if (char_have == 0) begin
          char_need = utf8_span(w.text_byte);
          char_bytes = '0;
        end
        char_bytes |= {24'd0, w.text_byte} << (8 * (char_have % 4));
        char_have++;
        if (char_have >= char_need) begin
          for (k = 0; k < atlas_used && hit < 0; k++) begin
            if (atlas_len[k] == char_need && atlas_key[k] == char_bytes) hit = k;
          end
          b.dst_x = POS_W'(pen_x);
          b.dst_y = pen_y;
          if (hit >= 0) begin
            b.found = 1'b1;
            b.match_index = MATCH_INDEX_W'(hit);
            b.src_x = atlas_rx[hit];
            b.src_y = atlas_ry[hit];
            b.src_w = atlas_rw[hit];
            b.src_h = atlas_rh[hit];
            b.dst_w = SIZE_W'(scaled_len(atlas_rw[hit]));
            b.dst_h = SIZE_W'(scaled_len(atlas_rh[hit]));
            pen_x = pen_x + scaled_len(atlas_adv[hit]);
            if (pen_x > int'(POS_MAX)) pen_x = int'(POS_MAX);
          end
          blits_due = {blits_due, b};
          char_bytes = '0;
          char_have = 0;
          char_need = 0;
        end
      end
      default: begin
      end
    endcase
  endtask

  function automatic word_t rand_word(cmd_t c);
    logic [159:0] r;
    word_t w;
    r = {$urandom, $urandom, $urandom, $urandom, $urandom};
    w = r[$bits(word_t)-1:0];
    w.command = c;
    return w;
  endfunction

  task automatic queue_word(input word_t w);
    pending_words = {pending_words, w};
  endtask

  task automatic push_clear();
    plan_key.delete();
    plan_len.delete();
    queue_word(rand_word(CMD_CLEAR));
  endtask

  task automatic push_append(input logic [KEY_W-1:0] key, input logic [KEY_LEN_W-1:0] len,
                             input logic [COORD_W-1:0] rx, input logic [COORD_W-1:0] ry,
                             input logic [COORD_W-1:0] rw, input logic [COORD_W-1:0] rh,
                             input logic [COORD_W-1:0] adv);
    word_t w;
    w = rand_word(CMD_APPEND);
    w.key_bytes = key;
    w.key_length = len;
    w.rect_x = rx;
    w.rect_y = ry;
    w.rect_w = rw;
    w.rect_h = rh;
    w.advance = adv;
    queue_word(w);
    if (plan_key.size() < GLYPHS) begin
      plan_key = {plan_key, key};
      plan_len = {plan_len, len};
    end
  endtask

  task automatic push_start(input logic [POS_W-1:0] ox, input logic [POS_W-1:0] oy,
                            input logic [SCALE_W-1:0] sc);
    word_t w;
    w = rand_word(CMD_START);
    w.origin_x = ox;
    w.origin_y = oy;
    w.scale_q4_8 = sc;
    queue_word(w);
  endtask

  task automatic push_text(input logic [BYTE_W-1:0] b);
    word_t w;
    w = rand_word(CMD_TEXT);
    w.text_byte = b;
    queue_word(w);
  endtask

  task automatic push_bytes(input logic [KEY_W-1:0] key, input int n);
    for (int k = 0; k < n; k++) push_text(key[k*8 +: 8]);
  endtask

  task automatic rand_char(output logic [KEY_W-1:0] key, output logic [KEY_LEN_W-1:0] len);
    key = $urandom;
    len = KEY_LEN_W'($urandom_range(1, 4));
    case (len)
      3'd1: key[7] = 1'b0;
      3'd2: key[7:5] = 3'b110;
      3'd3: key[7:4] = 4'b1110;
      default: key[7:3] = 5'b11110;
    endcase
  endtask

  function automatic logic [POS_W-1:0] pick_pos();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return POS_W'($urandom_range(0, 255));
      default: return POS_W'($urandom);
    endcase
  endfunction

  function automatic int draw_gap();
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm_left = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, MAX_GAP);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        layout_step(drv);
        words_taken++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_words.size() > 0) begin
          drv <= pending_words.pop_front();
          start <= 1'b1;
          gap_left = draw_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic cmp_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    blit_t want;
    if (rst_n && out_strobe) begin
      if (blits_due.size() == 0) begin
        $error("blit word strobed with no character pending");
        errors++;
      end else begin
        want = blits_due.pop_front();
        cmp_field("found", want.found, out_found);
        cmp_field("match_index", want.match_index, out_match_index);
        cmp_field("src_x", want.src_x, out_src_x);
        cmp_field("src_y", want.src_y, out_src_y);
        cmp_field("src_w", want.src_w, out_src_w);
        cmp_field("src_h", want.src_h, out_src_h);
        cmp_field("dst_x", $signed(want.dst_x), out_dst_x);
        cmp_field("dst_y", $signed(want.dst_y), out_dst_y);
        cmp_field("dst_w", want.dst_w, out_dst_w);
        cmp_field("dst_h", want.dst_h, out_dst_h);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [KEY_W-1:0] key;
    logic [KEY_LEN_W-1:0] len;
    int n;
    int m;
    int sel;
    int pick;

    // A lookup in an empty table, then duplicates, masked keys and odd lengths.
    push_text(8'h41);
    push_append(32'h0000_0041, 3'd1, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
    push_append(32'h0000_0041, 3'd1, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000);
    push_append(32'hDEAD_A9C3, 3'd2, 12'd1, 12'd2, 12'd3, 12'd4, 12'd256);
    push_append(32'h5AAC_82E2, 3'd3, 12'hA5A, 12'h5A5, 12'd17, 12'd33, 12'd100);
    push_append(32'h8098_9FF0, 3'd4, 12'h123, 12'h456, 12'h789, 12'hABC, 12'hDEF);
    push_append(32'h0000_0041, 3'd0, 12'd9, 12'd9, 12'd9, 12'd9, 12'd9);
    push_append(32'hFFFF_FFFF, 3'd7, 12'd7, 12'd7, 12'd7, 12'd7, 12'd7);
    push_start(16'h8000, 16'h7FFF, 12'hFFF);
    push_text(8'h41);
    push_bytes(32'h0000_A9C3, 2);
    push_bytes(32'h00AC_82E2, 3);
    push_start(16'h7FFF, 16'h8000, 12'h000);
    push_bytes(32'h0000_9FF0, 2);
    push_start(16'h0000, 16'h0000, 12'd256);
    push_text(8'h80);
    push_text(8'hFF);
    push_text(8'hE2);
    push_clear();
    push_text(8'h82);
    push_text(8'hAC);

    while (pending_words.size() < N_WORDS) begin
      if ($urandom_range(0, 6) == 0) push_clear();
      if ($urandom_range(0, 14) == 0) n = GLYPHS + 3 - plan_key.size();
      else n = $urandom_range(0, 10);
      repeat (n) begin
        sel = $urandom_range(0, 19);
        if (sel < 14 || plan_key.size() == 0) begin
          rand_char(key, len);
        end else if (sel < 17) begin
          pick = $urandom_range(0, plan_key.size() - 1);
          key = plan_key[pick];
          len = plan_len[pick];
        end else if (sel < 19) begin
          key = $urandom;
          len = KEY_LEN_W'($urandom_range(0, 7));
        end else begin
          key = $urandom;
          len = 3'd1;
        end
        push_append(key, len, COORD_W'($urandom), COORD_W'($urandom),
                    COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
      end

      case ($urandom_range(0, 5))
        0: push_start(pick_pos(), pick_pos(), 12'h000);
        1: push_start(pick_pos(), pick_pos(), 12'hFFF);
        2: push_start(pick_pos(), pick_pos(), SCALE_RESET);
        default: push_start(pick_pos(), pick_pos(), SCALE_W'($urandom));
      endcase

      m = $urandom_range(1, 24);
      repeat (m) begin
        sel = $urandom_range(0, 99);
        if (sel < 60 && plan_key.size() > 0) begin
          pick = $urandom_range(0, plan_key.size() - 1);
          n = plan_len[pick];
          if (n == 0) n = 1;
          if (n > 4) n = 4;
          push_bytes(plan_key[pick], n);
        end else if (sel < 80) begin
          rand_char(key, len);
          push_bytes(key, len);
        end else if (sel < 87) begin
          if ($urandom_range(0, 1) == 0) push_text({2'b10, 6'($urandom)});
          else push_text({5'b11111, 3'($urandom)});
        end else if (sel < 93) begin
          rand_char(key, len);
          if (len == 3'd1) len = 3'd2;
          key[7:6] = 2'b11;
          if (len == 3'd2) key[5] = 1'b0;
          push_bytes(key, $urandom_range(1, len - 1));
          if ($urandom_range(0, 1) == 0) push_start(pick_pos(), pick_pos(), SCALE_W'($urandom));
        end else if (sel < 96) begin
          rand_char(key, len);
          push_text(key[7:0]);
          push_clear();
          for (int k = 1; k < len; k++) push_text(key[k*8 +: 8]);
        end else begin
          push_text(BYTE_W'($urandom));
        end
      end
    end
    words_total = pending_words.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    while (words_taken < words_total) @(posedge clk);
    while (blits_due.size() > 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
